>>> rtl/core/upm_pkg.sv
package upm_pkg;

  localparam int unsigned LANES      = 3;
  localparam int unsigned QUO_BITS   = 8;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = QUO_BITS / DIV_STEPS;

  localparam int unsigned LANE_RED   = 0;
  localparam int unsigned LANE_GREEN = 1;
  localparam int unsigned LANE_BLUE  = 2;

  localparam logic [7:0] CHAN_MAX = 8'hff;

  typedef logic [7:0] byte_t;

  // partial division state carried down the pipe, one entry per colour lane
  typedef struct packed {
    byte_t                  alpha;
    logic [LANES-1:0]       sat;
    logic [LANES-1:0][7:0]  rem;
    logic [LANES-1:0][7:0]  low;
    logic [LANES-1:0][7:0]  quo;
  } upm_work_t;

endpackage

>>> rtl/core/bgra_premultiplied_to_rgba_straight.sv
// channel | handshake           | payload
// input   | in_valid / in_stall   | premul_blue, premul_green, premul_red, alpha_in
// output  | out_valid / out_stall | straight_red, straight_green, straight_blue, alpha_out
//
// one pixel per clock sustained while out_stall stays low
// pipe of one numerator stage plus four two-bit restoring divider stages
// synchronous active-high reset empties the pipe, payload registers are not reset
// each stage holds while the next is full and stalled, so empty slots close up
// with out_stall low throughout, in_stall stays low
module bgra_premultiplied_to_rgba_straight (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  upm_pkg::byte_t premul_blue,
  input  upm_pkg::byte_t premul_green,
  input  upm_pkg::byte_t premul_red,
  input  upm_pkg::byte_t alpha_in,
  output logic           out_valid,
  input  logic           out_stall,
  output upm_pkg::byte_t straight_red,
  output upm_pkg::byte_t straight_green,
  output upm_pkg::byte_t straight_blue,
  output upm_pkg::byte_t alpha_out
);
  import upm_pkg::*;

  logic      pipe_valid [DIV_STAGES+1];
  logic      pipe_stall [DIV_STAGES+1];
  upm_work_t pipe_work  [DIV_STAGES+1];
  upm_work_t last;
  logic      zero_alpha;

  upm_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .premul_blue  (premul_blue),
    .premul_green (premul_green),
    .premul_red   (premul_red),
    .alpha_in     (alpha_in),
    .work_valid   (pipe_valid[0]),
    .work_stall   (pipe_stall[0]),
    .work         (pipe_work[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    upm_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (pipe_valid[k]),
      .up_stall (pipe_stall[k]),
      .up_work  (pipe_work[k]),
      .dn_valid (pipe_valid[k+1]),
      .dn_stall (pipe_stall[k+1]),
      .dn_work  (pipe_work[k+1])
    );
  end

  assign pipe_stall[DIV_STAGES] = out_stall;
  assign last                   = pipe_work[DIV_STAGES];
  assign zero_alpha             = last.alpha == '0;

  // clamp where the channel reaches alpha, blank the pixel where alpha is zero
  assign straight_red   = zero_alpha ? '0 : (last.sat[LANE_RED]   ? CHAN_MAX : last.quo[LANE_RED]);
  assign straight_green = zero_alpha ? '0 : (last.sat[LANE_GREEN] ? CHAN_MAX : last.quo[LANE_GREEN]);
  assign straight_blue  = zero_alpha ? '0 : (last.sat[LANE_BLUE]  ? CHAN_MAX : last.quo[LANE_BLUE]);
  assign alpha_out      = last.alpha;
  assign out_valid      = pipe_valid[DIV_STAGES];

  a_no_stall_without_back_pressure : assert property (
    @(posedge clk) disable iff (rst) !out_stall |-> !in_stall
  ) else $error("input stalled with output free");

  a_quotient_below_max : assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !zero_alpha && !last.sat[LANE_RED] |-> last.quo[LANE_RED] != CHAN_MAX
  ) else $error("unclamped red quotient reached full scale");

  a_remainder_below_alpha : assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !zero_alpha && !last.sat[LANE_GREEN] |-> last.rem[LANE_GREEN] < last.alpha
  ) else $error("green remainder not below alpha");

endmodule

>>> rtl/core/upm_prep.sv
module upm_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  upm_pkg::byte_t    premul_blue,
  input  upm_pkg::byte_t    premul_green,
  input  upm_pkg::byte_t    premul_red,
  input  upm_pkg::byte_t    alpha_in,
  output logic              work_valid,
  input  logic              work_stall,
  output upm_pkg::upm_work_t work
);
  import upm_pkg::*;

  logic                   valid;
  upm_work_t              data;
  upm_work_t              data_next;
  logic [LANES-1:0][7:0]  chan;
  logic [LANES-1:0][15:0] num;

  assign chan[LANE_RED]   = premul_red;
  assign chan[LANE_GREEN] = premul_green;
  assign chan[LANE_BLUE]  = premul_blue;

  // numerator is chan*255 plus half the alpha, split into high and low bytes
  always_comb begin
    data_next.alpha = alpha_in;
    for (int i = 0; i < LANES; i++) begin
      num[i]               = ({chan[i], 8'h00} - {8'h00, chan[i]}) + {9'h000, alpha_in[7:1]};
      data_next.sat[i]     = chan[i] >= alpha_in;
      data_next.rem[i]     = num[i][15:8];
      data_next.low[i]     = num[i][7:0];
      data_next.quo[i]     = '0;
    end
  end

  assign in_stall = valid && work_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= data_next;
    end
  end

  assign work_valid = valid;
  assign work       = data;

endmodule

>>> rtl/core/upm_div_stage.sv
module upm_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  upm_pkg::upm_work_t up_work,
  output logic               dn_valid,
  input  logic               dn_stall,
  output upm_pkg::upm_work_t dn_work
);
  import upm_pkg::*;

  logic                  valid;
  upm_work_t             data;
  upm_work_t             data_next;
  logic [LANES-1:0][8:0] trial;
  logic [LANES-1:0]      fits;

  // restoring division, a couple of quotient bits per stage
  always_comb begin
    data_next = up_work;
    trial     = '0;
    fits      = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int i = 0; i < LANES; i++) begin
        trial[i]            = {data_next.rem[i], data_next.low[i][7]};
        fits[i]             = trial[i] >= {1'b0, data_next.alpha};
        data_next.rem[i]    = fits[i] ? 8'(trial[i] - {1'b0, data_next.alpha})
                                      : trial[i][7:0];
        data_next.low[i]    = {data_next.low[i][6:0], 1'b0};
        data_next.quo[i]    = {data_next.quo[i][6:0], fits[i]};
      end
    end
  end

  assign up_stall = valid && dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_work  = data;

endmodule

>>> test/straight_pixel_checker.sv
module straight_pixel_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  upm_pkg::byte_t premul_blue,
  input  upm_pkg::byte_t premul_green,
  input  upm_pkg::byte_t premul_red,
  input  upm_pkg::byte_t alpha_in,
  input  logic           out_valid,
  input  logic           out_stall,
  input  upm_pkg::byte_t straight_red,
  input  upm_pkg::byte_t straight_green,
  input  upm_pkg::byte_t straight_blue,
  input  upm_pkg::byte_t alpha_out,
  output int             mismatches,
  output int             pending
);
  import upm_pkg::*;

  localparam int unsigned FULL_SCALE = 255;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
  } rgba_t;

  rgba_t straight_due [$];

  function automatic byte_t unpremultiply(input byte_t chan, input byte_t alpha);
    int unsigned quotient;
    quotient = (int'(chan) * FULL_SCALE + int'(alpha) / 2) / int'(alpha);
    return (quotient > FULL_SCALE) ? upm_pkg::CHAN_MAX : byte_t'(quotient);
  endfunction

  function automatic rgba_t straighten_pixel(input byte_t blue, input byte_t green,
                                             input byte_t red, input byte_t alpha);
    rgba_t pixel;
    pixel = '0;
    if (alpha != 8'd0) begin
      pixel.red   = unpremultiply(red, alpha);
      pixel.green = unpremultiply(green, alpha);
      pixel.blue  = unpremultiply(blue, alpha);
      pixel.alpha = alpha;
    end
    return pixel;
  endfunction

  task automatic compare_channel(input string label, input byte_t want, input byte_t got);
    if (want !== got) begin
      $display("%0t: %s expected %02h, got %02h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rgba_t want;
    if (rst) begin
      mismatches = 0;
      straight_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (straight_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %02h %02h %02h %02h",
                   $time, straight_red, straight_green, straight_blue, alpha_out);
          mismatches++;
        end else begin
          want = straight_due.pop_front();
          compare_channel("straight_red", want.red, straight_red);
          compare_channel("straight_green", want.green, straight_green);
          compare_channel("straight_blue", want.blue, straight_blue);
          compare_channel("alpha_out", want.alpha, alpha_out);
        end
      end
      if (in_valid && !in_stall) begin
        straight_due.push_back(straighten_pixel(premul_blue, premul_green,
                                                premul_red, alpha_in));
      end
    end
    pending = straight_due.size();
  end

endmodule

>>> test/testbench.sv
module testbench;
  import upm_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned RANDOM_PIXELS = 1050;
  localparam int unsigned CALM_TAIL     = 150;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned DIRECTED_LEN  = 20;

  // blue, green, red, alpha
  localparam logic [31:0] DIRECTED [DIRECTED_LEN] = '{
    32'h00_00_00_00, 32'hff_ff_ff_00, 32'h12_34_56_00, 32'h00_00_00_ff,
    32'hff_ff_ff_ff, 32'hff_00_ff_01, 32'h00_ff_00_01, 32'h01_01_01_01,
    32'h01_01_00_02, 32'h01_02_03_03, 32'h80_40_c0_80, 32'hc8_64_32_0a,
    32'h7f_80_ff_fe, 32'hff_00_00_80, 32'h00_ff_00_80, 32'h00_00_ff_80,
    32'haa_55_aa_ff, 32'h55_aa_55_7f, 32'h03_02_01_04, 32'hff_fe_fd_fe
  };

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  in_valid     = 1'b0;
  logic  in_stall;
  byte_t premul_blue  = '0;
  byte_t premul_green = '0;
  byte_t premul_red   = '0;
  byte_t alpha_in     = '0;
  logic  out_valid;
  logic  out_stall    = 1'b0;
  byte_t straight_red;
  byte_t straight_green;
  byte_t straight_blue;
  byte_t alpha_out;

  int          fail_count;
  int          pending;
  bit          calm         = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  bgra_premultiplied_to_rgba_straight dut (.*);

  straight_pixel_checker pixel_check (
    .*,
    .mismatches (fail_count),
    .pending    (pending)
  );

  // output back-pressure in bursts
  always @(negedge clk) begin
    if (calm) begin
      out_stall = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 17);
    end else begin
      out_stall  = 1'b0;
      stall_left = $urandom_range(0, 24);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input byte_t b, input byte_t g, input byte_t r, input byte_t a);
    @(negedge clk);
    in_valid     = 1'b1;
    premul_blue  = b;
    premul_green = g;
    premul_red   = r;
    alpha_in     = a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_off_input(input int unsigned cycles);
    @(negedge clk);
    in_valid     = 1'b0;
    premul_blue  = byte_t'($urandom);
    premul_green = byte_t'($urandom);
    premul_red   = byte_t'($urandom);
    alpha_in     = byte_t'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    byte_t       b, g, r, a;
    int unsigned kind;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if ($urandom_range(0, 3) == 0) hold_off_input($urandom_range(1, 18));
      send_pixel(DIRECTED[i][31:24], DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);
    end

    for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS / 2) begin
        // let the pipe run dry before carrying on
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i == RANDOM_PIXELS - CALM_TAIL) calm = 1'b1;

      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        a = byte_t'($urandom_range(1, 255));
        b = byte_t'($urandom_range(0, a));
        g = byte_t'($urandom_range(0, a));
        r = byte_t'($urandom_range(0, a));
      end else if (kind < 17) begin
        a = byte_t'($urandom_range(1, 255));
        b = byte_t'($urandom);
        g = byte_t'($urandom);
        r = byte_t'($urandom);
      end else if (kind < 19) begin
        a = 8'd0;
        b = byte_t'($urandom);
        g = byte_t'($urandom);
        r = byte_t'($urandom);
      end else begin
        a = $urandom_range(0, 1) ? 8'hff : 8'h01;
        b = byte_t'($urandom);
        g = byte_t'($urandom);
        r = byte_t'($urandom);
      end

      if (!calm && $urandom_range(0, 3) == 0) hold_off_input($urandom_range(1, 18));
      send_pixel(b, g, r, a);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/upm_pkg.sv
rtl/core/upm_prep.sv
rtl/core/upm_div_stage.sv
rtl/core/bgra_premultiplied_to_rgba_straight.sv
test/straight_pixel_checker.sv
test/testbench.sv
